FILE: rtl/ble_midi_packet_encoder_defines.svh
// ------------------------------------------------------------------------
// BLE-MIDI packet encoder: assertion macros
// Shared concurrent assertion forms, clocked and held off during reset.
// ------------------------------------------------------------------------
`ifndef BLE_MIDI_PACKET_ENCODER_DEFINES_SVH
`define BLE_MIDI_PACKET_ENCODER_DEFINES_SVH

// Same-cycle implication
`define BME_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bme assertion failed");

// Next-cycle implication
`define BME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bme assertion failed");

`endif

FILE: rtl/bme_pkg.sv
// ------------------------------------------------------------------------
// bme_pkg
// Types and constants shared by the BLE-MIDI packet encoder modules.
// ------------------------------------------------------------------------
package bme_pkg;

	// Opcodes of an input beat
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	// Register indexes
	localparam logic REG_PAYLOAD_LIMIT = 1'b0;

	// Byte classes
	localparam logic [7:0] STATUS_MIN   = 8'h80;
	localparam logic [7:0] CHAN_MAX     = 8'hEF;
	localparam logic [7:0] REALTIME_MIN = 8'hF8;

	// Limit clamp and reset
	localparam int unsigned LIMIT_MIN   = 5;
	localparam int unsigned RESULT_CAP  = 64;
	localparam logic [6:0]  LIMIT_RESET = 7'd64;

	// Bytes one message can add: header, timestamp low, three MIDI bytes
	localparam int unsigned MSG_SLOTS = 5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_RD,
		S_WAIT,
		S_PLAN,
		S_WRITE
	} state_t;

	typedef struct packed {
		logic capture;
		logic rd_issue;
		logic out_load;
		logic rd_advance;
		logic fill_clear;
		logic plan;
		logic wr_step;
	} cmd_t;

	typedef struct packed {
		logic is_flush;
		logic fill_zero;
		logic no_fit;
		logic drain_last;
		logic out_free;
		logic wr_last;
	} sts_t;

endpackage

FILE: rtl/ble_midi_packet_encoder.sv
// ------------------------------------------------------------------------
// ble_midi_packet_encoder
// Packs timestamped MIDI messages into BLE-MIDI packets with running status.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+----------------------------------
//   in        | in_valid / in_ready   | opcode, status_byte, data_first,
//             |                       | data_second, message_length, stamp_ms
//   out       | out_valid / out_ready | packet_byte, packet_end
//   config    | APB psel/penable      | payload_limit at address 0
//
// An append that fits goes through accept, check and plan, then one
// store write per byte (1 to 5 bytes).
// Draining reads each byte via the store's registered read port, then waits
// for a free output register; flushes and overflowing appends drain this way.
// Reset is asynchronous and active low; the store has no clearing pass.
// A stalled out beat holds draining but not a waiting input beat once the
// last byte sits in the output register.
// ------------------------------------------------------------------------
module ble_midi_packet_encoder #(
	parameter int unsigned PACKET_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input beats
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [7:0]  status_byte,
	input  logic [6:0]  data_first,
	input  logic [6:0]  data_second,
	input  logic [1:0]  message_length,
	input  logic [12:0] stamp_ms,
	// Output beats
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  packet_byte,
	output logic        packet_end,
	// Configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import bme_pkg::*;

	cmd_t       cmd;
	sts_t       sts;
	logic [6:0] limit_q;
	logic       cfg_wr;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PAYLOAD_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= pwdata[6:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PAYLOAD_LIMIT) begin
			prdata = {25'd0, limit_q};
		end
	end

	bme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bme_dpath #(
		.PACKET_BYTES (PACKET_BYTES)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.limit          (limit_q),
		.opcode         (opcode),
		.status_byte    (status_byte),
		.data_first     (data_first),
		.data_second    (data_second),
		.message_length (message_length),
		.stamp_ms       (stamp_ms),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.packet_byte    (packet_byte),
		.packet_end     (packet_end)
	);

endmodule

FILE: rtl/bme_ram.sv
// ------------------------------------------------------------------------
// bme_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ------------------------------------------------------------------------
module bme_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held while idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/bme_ctrl.sv
// ------------------------------------------------------------------------
// bme_ctrl
// Sequencer: takes one beat, drains the pending packet when needed,
// then, for an append, writes the new message bytes into the packet store.
// ------------------------------------------------------------------------
module bme_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bme_pkg::sts_t sts,
	output bme_pkg::cmd_t cmd
);

	import bme_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.is_flush) begin
					state_d = sts.fill_zero ? S_IDLE : S_RD;
				end else if (!sts.fill_zero && sts.no_fit) begin
					state_d = S_RD;
				end else begin
					state_d = S_PLAN;
				end
			end
			S_RD: begin
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (sts.out_free) begin
					if (!sts.drain_last) begin
						state_d = S_RD;
					end else begin
						state_d = sts.is_flush ? S_IDLE : S_PLAN;
					end
				end
			end
			S_PLAN: begin
				state_d = S_WRITE;
			end
			S_WRITE: begin
				if (sts.wr_last) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_RD: begin
				cmd.rd_issue = 1'b1;
			end
			S_WAIT: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.fill_clear = sts.drain_last;
					cmd.rd_advance = !sts.drain_last;
				end
			end
			S_PLAN: begin
				cmd.plan = 1'b1;
			end
			S_WRITE: begin
				cmd.wr_step = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: rtl/bme_dpath.sv
// ------------------------------------------------------------------------
// bme_dpath
// Datapath: beat registers, packet store, fill count, running status,
// message byte list and the output register.
// ------------------------------------------------------------------------
`include "ble_midi_packet_encoder_defines.svh"

module bme_dpath #(
	parameter int unsigned PACKET_BYTES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bme_pkg::cmd_t cmd,
	output bme_pkg::sts_t sts,
	input  logic [6:0]    limit,
	input  logic          opcode,
	input  logic [7:0]    status_byte,
	input  logic [6:0]    data_first,
	input  logic [6:0]    data_second,
	input  logic [1:0]    message_length,
	input  logic [12:0]   stamp_ms,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    packet_byte,
	output logic          packet_end
);

	import bme_pkg::*;

	localparam int unsigned AW  = $clog2(PACKET_BYTES);
	localparam int unsigned FW  = $clog2(PACKET_BYTES + 1);
	localparam int unsigned LW  = FW + 2;
	localparam int unsigned TOP = (PACKET_BYTES < RESULT_CAP) ? PACKET_BYTES : RESULT_CAP;
	localparam int unsigned SW  = $clog2(MSG_SLOTS + 1);

	// Beat registers
	logic          op_q;
	logic [7:0]    st_q;
	logic [6:0]    d1_q;
	logic [6:0]    d2_q;
	logic [1:0]    len_q;
	logic [12:0]   ts_q;

	// Control state
	logic [FW-1:0] fill_q;
	logic [7:0]    rs_q;
	logic [AW-1:0] rd_q;
	logic [SW-1:0] wr_idx_q;
	logic [SW-1:0] wr_cnt_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_end_q;
	logic [7:0]    list_q [MSG_SLOTS];

	logic [7:0]    ram_rdata;
	logic [LW-1:0] lim_eff;
	logic [LW-1:0] need;
	logic          new_pkt;
	logic [7:0]    rs_eff;
	logic          match;
	logic [7:0]    m0, m1, m2;
	logic [1:0]    nb;
	logic [SW-1:0] cnt_d;
	logic [7:0]    rs_d;
	logic [7:0]    hdr, tsl;
	logic          wr_en;

	// Capture the beat; a zero length counts as one
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= opcode;
			st_q  <= status_byte;
			d1_q  <= data_first;
			d2_q  <= data_second;
			len_q <= (message_length == 2'd0) ? 2'd1 : message_length;
			ts_q  <= stamp_ms;
		end
	end

	// Clamp the limit to the legal packet size
	always_comb begin
		if (LW'(limit) < LW'(LIMIT_MIN)) begin
			lim_eff = LW'(LIMIT_MIN);
		end else if (LW'(limit) > LW'(TOP)) begin
			lim_eff = LW'(TOP);
		end else begin
			lim_eff = LW'(limit);
		end
	end

	assign need = LW'(len_q) + LW'(1) + LW'(fill_q);

	// Plan the bytes of this message
	assign new_pkt = (fill_q == '0);
	assign rs_eff  = new_pkt ? 8'h00 : rs_q;
	assign match   = (rs_eff != 8'h00) && (st_q == rs_eff);
	assign hdr     = {2'b10, ts_q[12:7]};
	assign tsl     = {1'b1, ts_q[6:0]};
	assign m0      = match ? {1'b0, d1_q} : st_q;
	assign m1      = match ? {1'b0, d2_q} : {1'b0, d1_q};
	assign m2      = {1'b0, d2_q};
	assign nb      = match ? (len_q - 2'd1) : len_q;
	assign cnt_d   = SW'(new_pkt) + SW'(1) + SW'(nb);

	// Update running status
	always_comb begin
		rs_d = rs_eff;
		if (!match && (st_q < REALTIME_MIN)) begin
			if (st_q inside {[STATUS_MIN:CHAN_MAX]}) begin
				rs_d = st_q;
			end else begin
				rs_d = 8'h00;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.plan) begin
			if (new_pkt) begin
				list_q[0] <= hdr;
				list_q[1] <= tsl;
				list_q[2] <= m0;
				list_q[3] <= m1;
				list_q[4] <= m2;
			end else begin
				list_q[0] <= tsl;
				list_q[1] <= m0;
				list_q[2] <= m1;
				list_q[3] <= m2;
				list_q[4] <= m2;
			end
			wr_cnt_q <= cnt_d;
		end
	end

	assign wr_en = cmd.wr_step && (fill_q < FW'(PACKET_BYTES));

	// Fill count, running status, drain and write indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rs_q     <= 8'h00;
			rd_q     <= '0;
			wr_idx_q <= '0;
		end else begin
			if (cmd.plan) begin
				rs_q     <= rs_d;
				wr_idx_q <= '0;
			end
			if (cmd.wr_step) begin
				wr_idx_q <= wr_idx_q + SW'(1);
			end
			if (wr_en) begin
				fill_q <= fill_q + FW'(1);
			end
			if (cmd.fill_clear) begin
				fill_q <= '0;
				rd_q   <= '0;
			end else if (cmd.rd_advance) begin
				rd_q <= rd_q + AW'(1);
			end
		end
	end

	bme_ram #(
		.WIDTH (8),
		.DEPTH (PACKET_BYTES)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (fill_q[AW-1:0]),
		.wdata (list_q[wr_idx_q]),
		.re    (cmd.rd_issue),
		.raddr (rd_q),
		.rdata (ram_rdata)
	);

	// Output register: load a drained byte, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_byte_q <= ram_rdata;
			out_end_q  <= sts.drain_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign packet_byte = out_byte_q;
	assign packet_end  = out_end_q;

	// Status to the sequencer
	always_comb begin
		sts            = '0;
		sts.is_flush   = (op_q == OP_FLUSH);
		sts.fill_zero  = new_pkt;
		sts.no_fit     = (need > lim_eff);
		sts.drain_last = ((FW'(rd_q) + FW'(1)) == fill_q);
		sts.out_free   = !out_valid_q || out_ready;
		sts.wr_last    = (wr_idx_q + SW'(1) == wr_cnt_q);
	end

	`BME_ASSERT_IMP(a_fill_cap, clk, arst_n, 1'b1, fill_q <= FW'(TOP))
	`BME_ASSERT_NEXT(a_fill_clear, clk, arst_n, cmd.fill_clear, fill_q == '0)
	`BME_ASSERT_IMP(a_load_free, clk, arst_n, cmd.out_load, sts.out_free)

endmodule
